/* design/timed_entry_table_with_view_cull_unit_assert.svh */
// Assertion macros for the timed entry table with view cull unit
`ifndef TIMED_ENTRY_TABLE_WITH_VIEW_CULL_UNIT_ASSERT_SVH
`define TIMED_ENTRY_TABLE_WITH_VIEW_CULL_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TETVC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tetvc assertion failed");

// Next-cycle implication, checked out of reset
`define TETVC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tetvc assertion failed");

`endif

/* design/tetvc_pkg.sv */
// Shared types and constants of the timed entry table with view cull unit
`timescale 1ns / 1ps
`default_nettype none
package tetvc_pkg;

   localparam int MAX_ENTRIES     = 64;
   localparam int MAX_RESULTS_OUT = 64;
   localparam int IDX_W           = $clog2(MAX_ENTRIES);
   localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
   localparam int OUT_W           = $clog2(MAX_RESULTS_OUT + 1);
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_SCAN  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic REG_UPDATE_PERIOD = 1'b0;
   localparam logic REG_DEATH_STAGE   = 1'b1;

   localparam logic [7:0] UPDATE_PERIOD_RESET = 8'd8;
   localparam logic [7:0] DEATH_STAGE_RESET   = 8'd0;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      logic [7:0] map_x;
      logic [7:0] map_y;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] stage;
   } entry_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] map_x;
      logic [7:0] map_y;
      logic [7:0] in_pixel_x;
      logic [7:0] in_pixel_y;
      logic [7:0] start_stage;
      logic [7:0] view_left;
      logic [7:0] view_right;
      logic [7:0] view_top;
      logic [7:0] view_bottom;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic       status;
      logic [7:0] screen_x;
      logic [7:0] screen_y;
      logic [7:0] shown_pixel_x;
      logic [7:0] shown_pixel_y;
      logic [7:0] shown_stage;
      logic       last;
   } rsp_type;

   // Control broadcast from the sequencer to the row of cells
   typedef struct packed {
      cell_op_type      op;
      logic             ins_en;
      logic [IDX_W-1:0] ins_idx;
      entry_type        ins_data;
      entry_type        new_data;
   } chain_ctl_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } ctrl_stat_type;

endpackage
`default_nettype wire

/* design/tetvc_cell.sv */
// One entry cell of the shifting entry chain
`timescale 1ns / 1ps
`default_nettype none
module tetvc_cell (
   input  wire                   clock,
   input  tetvc_pkg::cell_op_type op,
   input  wire                   hit,
   input  tetvc_pkg::entry_type  up_data,
   input  tetvc_pkg::entry_type  dn_data,
   input  tetvc_pkg::entry_type  ins_data,
   output tetvc_pkg::entry_type  data_q
);
   import tetvc_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   always_comb begin
      case (op)
         CELL_PUSH: data_in = up_data;
         // pop moves toward the head; the recirculation slot takes the insert bus
         CELL_POP:  data_in = hit ? ins_data : dn_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule
`default_nettype wire

/* design/tetvc_ctrl.sv */
// Command sequencer: count, tick, aging and scan passes, result register
`timescale 1ns / 1ps
`default_nettype none
module tetvc_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  tetvc_pkg::req_type       req,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output tetvc_pkg::rsp_type       rsp,
   input  wire [7:0]                update_period,
   input  wire [7:0]                death_stage,
   input  tetvc_pkg::entry_type     head,
   output tetvc_pkg::chain_ctl_type chain_ctl,
   output tetvc_pkg::ctrl_stat_type stat
);
   import tetvc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AGE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [7:0]       tick_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W-1:0] kept_ff;
   logic [OUT_W-1:0] n_ff;
   logic             pend_valid_ff;
   rsp_type          pend_ff;
   logic [7:0]       left_ff;
   logic [7:0]       right_ff;
   logic [7:0]       top_ff;
   logic [7:0]       bottom_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             out_free;
   logic             accept;
   logic             full;
   logic [7:0]       tick_in;
   logic             age_now;
   logic             have_rem;
   logic             vis;
   logic             take;
   logic             surv;
   logic             scan_step;
   logic             age_step;
   logic [CNT_W-1:0] pos_sum;
   rsp_type          vis_rsp;
   rsp_type          ok_rsp;
   rsp_type          pend_last;
   logic             emit;
   rsp_type          emit_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= CNT_W'(MAX_ENTRIES));
   assign tick_in   = tick_ff + 8'd1;
   assign age_now   = (tick_in == update_period);
   assign have_rem  = (rem_ff != '0);

   assign vis  = (head.map_x >= left_ff) && (head.map_x < right_ff) &&
                 (head.map_y >= top_ff)  && (head.map_y < bottom_ff);
   assign take = vis && (n_ff < OUT_W'(MAX_RESULTS_OUT));
   assign surv = (head.stage > death_stage);

   // stall the scan step only when a held result has nowhere to go
   assign scan_step = (state_ff == ST_SCAN) && have_rem &&
                      !(take && pend_valid_ff && !out_free);
   assign age_step  = (state_ff == ST_AGE) && have_rem;

   // unprocessed entries sit ahead of the already kept ones
   assign pos_sum = rem_ff + kept_ff - CNT_W'(1);

   always_comb begin
      ok_rsp        = '0;
      ok_rsp.kind   = KIND_STATUS;
      ok_rsp.status = STATUS_OK;
      ok_rsp.last   = 1'b1;

      vis_rsp               = '0;
      vis_rsp.kind          = KIND_ENTRY;
      vis_rsp.status        = STATUS_OK;
      vis_rsp.screen_x      = head.map_x - left_ff;
      vis_rsp.screen_y      = head.map_y - top_ff;
      vis_rsp.shown_pixel_x = head.pixel_x;
      vis_rsp.shown_pixel_y = head.pixel_y;
      vis_rsp.shown_stage   = head.stage;
      vis_rsp.last          = 1'b0;

      pend_last      = pend_ff;
      pend_last.last = 1'b1;
   end

   always_comb begin
      chain_ctl                  = '0;
      chain_ctl.op               = CELL_HOLD;
      chain_ctl.ins_idx          = pos_sum[IDX_W-1:0];
      chain_ctl.ins_data         = head;
      chain_ctl.new_data.map_x   = req.map_x;
      chain_ctl.new_data.map_y   = req.map_y;
      chain_ctl.new_data.pixel_x = req.in_pixel_x;
      chain_ctl.new_data.pixel_y = req.in_pixel_y;
      chain_ctl.new_data.stage   = req.start_stage;
      if (state_ff == ST_AGE) begin
         chain_ctl.ins_data.stage = head.stage - 8'd1;
      end
      if (accept && (req.command == CMD_ADD) && !full) begin
         chain_ctl.op = CELL_PUSH;
      end else if (scan_step || age_step) begin
         chain_ctl.op     = CELL_POP;
         chain_ctl.ins_en = scan_step || (age_step && surv);
      end
   end

   always_comb begin
      emit      = 1'b0;
      emit_data = ok_rsp;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.command)
                  CMD_ADD: begin
                     emit             = 1'b1;
                     emit_data.status = full ? STATUS_FULL : STATUS_OK;
                  end
                  CMD_TICK:  emit = !age_now;
                  CMD_SCAN:  emit = 1'b0;
                  CMD_CLEAR: emit = 1'b1;
                  default:   emit = 1'b0;
               endcase
            end
         end
         ST_SCAN: begin
            if (have_rem) begin
               if (scan_step && take && pend_valid_ff) begin
                  emit      = 1'b1;
                  emit_data = pend_ff;
               end
            end else if (out_free) begin
               emit      = 1'b1;
               emit_data = pend_valid_ff ? pend_last : ok_rsp;
            end
         end
         ST_AGE: begin
            emit = !have_rem && out_free;
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         tick_ff       <= '0;
         rem_ff        <= '0;
         kept_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= emit_data;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req.command)
                     CMD_ADD: begin
                        if (!full) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     CMD_TICK: begin
                        if (age_now) begin
                           tick_ff  <= '0;
                           rem_ff   <= count_ff;
                           kept_ff  <= '0;
                           state_ff <= ST_AGE;
                        end else begin
                           tick_ff <= tick_in;
                        end
                     end
                     CMD_SCAN: begin
                        left_ff       <= req.view_left;
                        right_ff      <= req.view_right;
                        top_ff        <= req.view_top;
                        bottom_ff     <= req.view_bottom;
                        rem_ff        <= count_ff;
                        kept_ff       <= '0;
                        n_ff          <= '0;
                        pend_valid_ff <= 1'b0;
                        state_ff      <= ST_SCAN;
                     end
                     CMD_CLEAR: count_ff <= '0;
                     default:   count_ff <= count_ff;
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_step) begin
                  rem_ff  <= rem_ff - CNT_W'(1);
                  kept_ff <= kept_ff + CNT_W'(1);
                  if (take) begin
                     pend_ff       <= vis_rsp;
                     pend_valid_ff <= 1'b1;
                     n_ff          <= n_ff + OUT_W'(1);
                  end
               end
               if (!have_rem && out_free) begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_AGE: begin
               if (age_step) begin
                  rem_ff <= rem_ff - CNT_W'(1);
                  if (surv) begin
                     kept_ff <= kept_ff + CNT_W'(1);
                  end
               end
               if (!have_rem) begin
                  count_ff <= kept_ff;
                  if (out_free) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign stat.busy  = (state_ff != ST_IDLE);
   assign stat.count = count_ff;

endmodule
`default_nettype wire

/* design/timed_entry_table_with_view_cull_unit.sv */
// Results: add, clear and a tick without aging give their status in the cycle after the transfer.
// A tick that ages, and a scan, walk the entry chain one cell per cycle; a scan pauses while a
// new result waits behind a held one that cannot leave. A scan delivers its results while walking.
// The unit takes one item at a time: a request is accepted only when idle and the output is free.
// Reset: synchronous, active high; empties the table, zeroes the tick count and loads the
// register defaults. Entry cells are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "timed_entry_table_with_view_cull_unit_assert.svh"
module timed_entry_table_with_view_cull_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [1:0]                       req_command,
   input  wire  [7:0]                       req_map_x,
   input  wire  [7:0]                       req_map_y,
   input  wire  [7:0]                       req_in_pixel_x,
   input  wire  [7:0]                       req_in_pixel_y,
   input  wire  [7:0]                       req_start_stage,
   input  wire  [7:0]                       req_view_left,
   input  wire  [7:0]                       req_view_right,
   input  wire  [7:0]                       req_view_top,
   input  wire  [7:0]                       req_view_bottom,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_kind,
   output logic                             rsp_status,
   output logic [7:0]                       rsp_screen_x,
   output logic [7:0]                       rsp_screen_y,
   output logic [7:0]                       rsp_shown_pixel_x,
   output logic [7:0]                       rsp_shown_pixel_y,
   output logic [7:0]                       rsp_shown_stage,
   output logic                             rsp_last,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [tetvc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire  [tetvc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tetvc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import tetvc_pkg::*;

   logic [7:0]           update_period_ff;
   logic [7:0]           death_stage_ff;
   logic                 csr_write;
   logic                 csr_index;

   req_type              req;
   rsp_type              rsp;
   chain_ctl_type        chain_ctl;
   ctrl_stat_type        stat;
   entry_type            cell_q [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] hit;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         update_period_ff <= UPDATE_PERIOD_RESET;
         death_stage_ff   <= DEATH_STAGE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_UPDATE_PERIOD: update_period_ff <= csr_pwdata[7:0];
            REG_DEATH_STAGE:   death_stage_ff   <= csr_pwdata[7:0];
            default:           update_period_ff <= update_period_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_UPDATE_PERIOD: csr_prdata[7:0] = update_period_ff;
         REG_DEATH_STAGE:   csr_prdata[7:0] = death_stage_ff;
         default:           csr_prdata      = '0;
      endcase
   end

   assign req.command     = req_command;
   assign req.map_x       = req_map_x;
   assign req.map_y       = req_map_y;
   assign req.in_pixel_x  = req_in_pixel_x;
   assign req.in_pixel_y  = req_in_pixel_y;
   assign req.start_stage = req_start_stage;
   assign req.view_left   = req_view_left;
   assign req.view_right  = req_view_right;
   assign req.view_top    = req_view_top;
   assign req.view_bottom = req_view_bottom;

   tetvc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req           (req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp           (rsp),
      .update_period (update_period_ff),
      .death_stage   (death_stage_ff),
      .head          (cell_q[0]),
      .chain_ctl     (chain_ctl),
      .stat          (stat)
   );

   // entry chain, newest at cell 0
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type up_data;
      entry_type dn_data;

      assign hit[i] = chain_ctl.ins_en && (chain_ctl.ins_idx == IDX_W'(i));

      if (i == 0) begin : g_head
         assign up_data = chain_ctl.new_data;
      end else begin : g_mid_up
         assign up_data = cell_q[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign dn_data = cell_q[i];
      end else begin : g_mid_dn
         assign dn_data = cell_q[i+1];
      end

      tetvc_cell u_cell (
         .clock    (clock),
         .op       (chain_ctl.op),
         .hit      (hit[i]),
         .up_data  (up_data),
         .dn_data  (dn_data),
         .ins_data (chain_ctl.ins_data),
         .data_q   (cell_q[i])
      );
   end

   assign rsp_kind          = rsp.kind;
   assign rsp_status        = rsp.status;
   assign rsp_screen_x      = rsp.screen_x;
   assign rsp_screen_y      = rsp.screen_y;
   assign rsp_shown_pixel_x = rsp.shown_pixel_x;
   assign rsp_shown_pixel_y = rsp.shown_pixel_y;
   assign rsp_shown_stage   = rsp.shown_stage;
   assign rsp_last          = rsp.last;

   `TETVC_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= CNT_W'(MAX_ENTRIES))
   `TETVC_ASSERT_NOW(a_push_on_add, chain_ctl.op == CELL_PUSH,
                     req_valid && !req_stall && (req_command == CMD_ADD))
   `TETVC_ASSERT_NOW(a_pop_when_busy, chain_ctl.op == CELL_POP, stat.busy)
   `TETVC_ASSERT_NEXT(a_transfer_progress, req_valid && !req_stall, stat.busy || rsp_valid)

endmodule
`default_nettype wire

/* tb/sv/timed_entry_table_with_view_cull_unit_tb.sv */
// Self-checking testbench for the timed entry table with view cull unit
`timescale 1ns / 1ps
module timed_entry_table_with_view_cull_unit_tb;
   import tetvc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 400;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PERIOD = CSR_ADDR_W'(4 * REG_UPDATE_PERIOD);
   localparam logic [CSR_ADDR_W-1:0] ADDR_DEATH  = CSR_ADDR_W'(4 * REG_DEATH_STAGE);

   typedef struct {
      req_type req;
      bit      typed;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_command;
   logic [7:0]            req_map_x;
   logic [7:0]            req_map_y;
   logic [7:0]            req_in_pixel_x;
   logic [7:0]            req_in_pixel_y;
   logic [7:0]            req_start_stage;
   logic [7:0]            req_view_left;
   logic [7:0]            req_view_right;
   logic [7:0]            req_view_top;
   logic [7:0]            req_view_bottom;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_kind;
   logic                  rsp_status;
   logic [7:0]            rsp_screen_x;
   logic [7:0]            rsp_screen_y;
   logic [7:0]            rsp_shown_pixel_x;
   logic [7:0]            rsp_shown_pixel_y;
   logic [7:0]            rsp_shown_stage;
   logic                  rsp_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the table: oldest entry first, newest last
   entry_type  mirror_entries[$];
   logic [7:0] mirror_ticks;
   logic [7:0] mirror_period;
   logic [7:0] mirror_death;

   rsp_type step_results[$];
   rsp_type awaited_results[$];
   int      mismatch_count = 0;
   bit      send_calm = 1'b0;
   bit      long_hold_pending = 1'b0;

   timed_entry_table_with_view_cull_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_map_x         (req_map_x),
      .req_map_y         (req_map_y),
      .req_in_pixel_x    (req_in_pixel_x),
      .req_in_pixel_y    (req_in_pixel_y),
      .req_start_stage   (req_start_stage),
      .req_view_left     (req_view_left),
      .req_view_right    (req_view_right),
      .req_view_top      (req_view_top),
      .req_view_bottom   (req_view_bottom),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_screen_x      (rsp_screen_x),
      .rsp_screen_y      (rsp_screen_y),
      .rsp_shown_pixel_x (rsp_shown_pixel_x),
      .rsp_shown_pixel_y (rsp_shown_pixel_y),
      .rsp_shown_stage   (rsp_shown_stage),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type status_result(input logic status);
      rsp_type r;
      r = '0;
      r.kind   = KIND_STATUS;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   // Apply one command to the mirror and collect the results it causes
   function automatic void predict_step(input req_type r);
      entry_type e;
      entry_type survivors[$];
      rsp_type   v;
      int        n;
      step_results.delete();
      case (r.command)
         CMD_ADD: begin
            if (mirror_entries.size() >= MAX_ENTRIES) begin
               step_results.push_back(status_result(STATUS_FULL));
            end else begin
               e.map_x   = r.map_x;
               e.map_y   = r.map_y;
               e.pixel_x = r.in_pixel_x;
               e.pixel_y = r.in_pixel_y;
               e.stage   = r.start_stage;
               mirror_entries.push_back(e);
               step_results.push_back(status_result(STATUS_OK));
            end
         end
         CMD_TICK: begin
            mirror_ticks = 8'(mirror_ticks + 8'd1);
            if (mirror_ticks == mirror_period) begin
               mirror_ticks = 8'd0;
               foreach (mirror_entries[k]) begin
                  e = mirror_entries[k];
                  if (e.stage > mirror_death) begin
                     e.stage = 8'(e.stage - 8'd1);
                     survivors.push_back(e);
                  end
               end
               mirror_entries = survivors;
            end
            step_results.push_back(status_result(STATUS_OK));
         end
         CMD_SCAN: begin
            n = 0;
            for (int i = mirror_entries.size() - 1; i >= 0 && n < MAX_RESULTS_OUT; i--) begin
               e = mirror_entries[i];
               if (e.map_x >= r.view_left && e.map_x < r.view_right &&
                   e.map_y >= r.view_top && e.map_y < r.view_bottom) begin
                  v = '0;
                  v.kind          = KIND_ENTRY;
                  v.status        = STATUS_OK;
                  v.screen_x      = 8'(e.map_x - r.view_left);
                  v.screen_y      = 8'(e.map_y - r.view_top);
                  v.shown_pixel_x = e.pixel_x;
                  v.shown_pixel_y = e.pixel_y;
                  v.shown_stage   = e.stage;
                  step_results.push_back(v);
                  n++;
               end
            end
            if (n == 0) step_results.push_back(status_result(STATUS_OK));
            else step_results[n-1].last = 1'b1;
         end
         default: begin
            mirror_entries.delete();
            step_results.push_back(status_result(STATUS_OK));
         end
      endcase
   endfunction

   function automatic directed_row_type row(
      input logic [1:0] cmd, input logic [7:0] mx, my, px, py, st,
      input logic [7:0] vl, vr, vt, vb, input bit typed);
      directed_row_type d;
      d.req.command     = cmd;
      d.req.map_x       = mx;
      d.req.map_y       = my;
      d.req.in_pixel_x  = px;
      d.req.in_pixel_y  = py;
      d.req.start_stage = st;
      d.req.view_left   = vl;
      d.req.view_right  = vr;
      d.req.view_top    = vt;
      d.req.view_bottom = vb;
      d.typed           = typed;
      return d;
   endfunction

   function automatic req_type random_item(input logic [1:0] cmd);
      req_type r;
      r.command     = cmd;
      r.map_x       = 8'($urandom_range(255, 0));
      r.map_y       = 8'($urandom_range(255, 0));
      r.in_pixel_x  = 8'($urandom_range(255, 0));
      r.in_pixel_y  = 8'($urandom_range(255, 0));
      // favor low stages so that aging removes entries
      r.start_stage = $urandom_range(1, 0) ? 8'($urandom_range(8, 0))
                                            : 8'($urandom_range(255, 0));
      if ($urandom_range(3, 0) != 0) begin
         r.view_left   = 8'($urandom_range(200, 0));
         r.view_right  = 8'($urandom_range(255, int'(r.view_left) + 1));
         r.view_top    = 8'($urandom_range(200, 0));
         r.view_bottom = 8'($urandom_range(255, int'(r.view_top) + 1));
      end else begin
         r.view_left   = 8'($urandom_range(255, 0));
         r.view_right  = 8'($urandom_range(255, 0));
         r.view_top    = 8'($urandom_range(255, 0));
         r.view_bottom = 8'($urandom_range(255, 0));
      end
      return r;
   endfunction

   function automatic req_type full_view_scan();
      req_type r;
      r = random_item(CMD_SCAN);
      r.view_left   = 8'd0;
      r.view_right  = 8'd255;
      r.view_top    = 8'd0;
      r.view_bottom = 8'd255;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input req_type r, input bit typed);
      int gap;
      gap = send_calm ? 0 : $urandom_range(15, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= r.command;
      req_map_x       <= r.map_x;
      req_map_y       <= r.map_y;
      req_in_pixel_x  <= r.in_pixel_x;
      req_in_pixel_y  <= r.in_pixel_y;
      req_start_stage <= r.start_stage;
      req_view_left   <= r.view_left;
      req_view_right  <= r.view_right;
      req_view_top    <= r.view_top;
      req_view_bottom <= r.view_bottom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_step(r);
      if (typed) awaited_results.push_back(status_result(STATUS_OK));
      else foreach (step_results[k]) awaited_results.push_back(step_results[k]);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_results.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_PERIOD) mirror_period = value;
      else mirror_death = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] want);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[7:0] !== want) begin
         $display("%0t: register at %0h expected %0h got %0h", $time, addr, want,
                  csr_prdata[7:0]);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] period, input logic [7:0] death);
      wait_drained();
      csr_write(ADDR_PERIOD, period);
      csr_write(ADDR_DEATH, death);
      csr_read_check(ADDR_PERIOD, period);
      csr_read_check(ADDR_DEATH, death);
   endtask

   task automatic run_random(input int count);
      int         pick;
      logic [1:0] cmd;
      send_calm = ($urandom_range(3, 0) == 0);
      repeat (count) begin
         pick = $urandom_range(99, 0);
         cmd  = (pick < 45) ? CMD_ADD : (pick < 70) ? CMD_TICK :
                (pick < 96) ? CMD_SCAN : CMD_CLEAR;
         send_item(random_item(cmd), 1'b0);
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, kind %0h status %0h last %0h", $time,
                     rsp_kind, rsp_status, rsp_last);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("status", want.status, rsp_status);
            check_field("screen_x", want.screen_x, rsp_screen_x);
            check_field("screen_y", want.screen_y, rsp_screen_y);
            check_field("shown_pixel_x", want.shown_pixel_x, rsp_shown_pixel_x);
            check_field("shown_pixel_y", want.shown_pixel_y, rsp_shown_pixel_y);
            check_field("shown_stage", want.shown_stage, rsp_shown_stage);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Result side: stall a drawn number of cycles before each transfer
   initial begin : rsp_pacing
      int hold;
      bit calm;
      calm      = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(23, 0) == 0) calm = ~calm;
         hold = calm ? 0 : $urandom_range(15, 0);
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      directed_row_type directed_rows[$];
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_ADD;
      req_map_x       = 8'd0;
      req_map_y       = 8'd0;
      req_in_pixel_x  = 8'd0;
      req_in_pixel_y  = 8'd0;
      req_start_stage = 8'd0;
      req_view_left   = 8'd0;
      req_view_right  = 8'd0;
      req_view_top    = 8'd0;
      req_view_bottom = 8'd0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      mirror_ticks    = 8'd0;
      mirror_period   = UPDATE_PERIOD_RESET;
      mirror_death    = DEATH_STAGE_RESET;

      // cmd, map x/y, pixel x/y, stage, view left/right/top/bottom, typed
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   0,   255, 0,   255, 1));
      directed_rows.push_back(row(CMD_TICK,  0,   0,   0,   0,   0,   0,   0,   0,   0,   1));
      directed_rows.push_back(row(CMD_ADD,   0,   0,   0,   0,   0,   255, 255, 255, 255, 1));
      directed_rows.push_back(row(CMD_ADD,   255, 255, 255, 255, 255, 0,   0,   0,   0,   1));
      directed_rows.push_back(row(CMD_ADD,   10,  20,  170, 85,  3,   0,   0,   0,   0,   1));
      directed_rows.push_back(row(CMD_ADD,   200, 100, 85,  170, 128, 0,   0,   0,   0,   1));
      directed_rows.push_back(row(CMD_ADD,   254, 254, 1,   2,   1,   0,   0,   0,   0,   1));
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   0,   255, 0,   255, 0));
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   5,   201, 15,  101, 0));
      // inverted and empty windows show nothing
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   100, 50,  0,   255, 1));
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   10,  10,  0,   255, 1));
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   0,   255, 60,  60,  1));
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   0,   255, 200, 20,  1));
      repeat (7) directed_rows.push_back(row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   0,   255, 0,   255, 0));
      directed_rows.push_back(row(CMD_CLEAR, 0,   0,   0,   0,   0,   0,   0,   0,   0,   1));
      directed_rows.push_back(row(CMD_SCAN,  0,   0,   0,   0,   0,   0,   255, 0,   255, 1));
      directed_rows.push_back(row(CMD_ADD,   128, 64,  15,  240, 9,   0,   0,   0,   0,   1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_read_check(ADDR_PERIOD, UPDATE_PERIOD_RESET);
      csr_read_check(ADDR_DEATH, DEATH_STAGE_RESET);

      foreach (directed_rows[k]) send_item(directed_rows[k].req, directed_rows[k].typed);
      run_random(15);

      // realign the tick count so that a period of one ages on every tick
      while (mirror_ticks != 8'd0) send_item(random_item(CMD_TICK), 1'b0);
      configure(8'd1, 8'd0);
      run_random(15);

      configure(8'd3, 8'd5);
      run_random(15);

      // fill the table past capacity while results back up
      configure(8'd255, 8'd255);
      send_item(random_item(CMD_CLEAR), 1'b0);
      long_hold_pending = 1'b1;
      repeat (MAX_ENTRIES + 2) send_item(random_item(CMD_ADD), 1'b0);
      send_item(full_view_scan(), 1'b0);

      // a period of zero only ages after the counter wraps
      configure(8'd0, 8'd10);
      run_random(5);

      configure(8'd2, 8'd255);
      run_random(5);

      wait_drained();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
